// File: hdl/hnls_pkg.sv
// Shared types and constants for the hot/normal lane scheduler.
// No dependencies; imported by every module of the block.

package hnls_pkg;

   // Default lane geometry and task id width
   localparam int HOT_DEPTH_DEF    = 256;
   localparam int NORMAL_DEPTH_DEF = 256;
   localparam int TASK_ID_BITS_DEF = 16;

   // Result occupancy fields are fixed at 9 bits (wrap above 511)
   localparam int COUNT_BITS = 9;

   // Configuration registers
   localparam int CFG_BITS     = 8;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [2:0] REG_HOT_MARGIN             = 3'd0;
   localparam logic [2:0] REG_CAP_CALM               = 3'd1;
   localparam logic [2:0] REG_CAP_CALM_CONTENDED     = 3'd2;
   localparam logic [2:0] REG_CAP_PRESSURE           = 3'd3;
   localparam logic [2:0] REG_CAP_PRESSURE_CONTENDED = 3'd4;

   localparam logic [CFG_BITS-1:0] HOT_MARGIN_RST             = 8'd8;
   localparam logic [CFG_BITS-1:0] CAP_CALM_RST               = 8'd8;
   localparam logic [CFG_BITS-1:0] CAP_CALM_CONTENDED_RST     = 8'd4;
   localparam logic [CFG_BITS-1:0] CAP_PRESSURE_RST           = 8'd2;
   localparam logic [CFG_BITS-1:0] CAP_PRESSURE_CONTENDED_RST = 8'd1;

   // Item kinds
   localparam logic KIND_ENQUEUE = 1'b0;
   localparam logic KIND_DEQUEUE = 1'b1;

   // Hot streak saturates here
   localparam logic [7:0] STREAK_MAX = 8'd255;

   // Register file contents handed to the scheduling logic
   typedef struct packed {
      logic [CFG_BITS-1:0] hot_margin;
      logic [CFG_BITS-1:0] cap_calm;
      logic [CFG_BITS-1:0] cap_calm_contended;
      logic [CFG_BITS-1:0] cap_pressure;
      logic [CFG_BITS-1:0] cap_pressure_contended;
   } cfg_type;

   // Lane command from the scheduler
   typedef struct packed {
      logic push;
      logic pop;
   } lane_cmd_type;

   // Lane occupancy flags back to the scheduler
   typedef struct packed {
      logic empty;
      logic full;
   } lane_stat_type;

endpackage

// File: hdl/hot_normal_lane_scheduler.sv
// Hot/normal two-lane task scheduler: top level with placement and pop policy.
// Depends on hnls_pkg, hnls_csr and hnls_lane.
//
// Each request is one enqueue or dequeue and returns exactly one response.
// The block takes one request per clock while responses drain. The lane
// decision and store access happen at the request transfer, where the store
// read data and the item's flags are registered into a pending stage, which
// moves them into the output register once that register is free. A
// response thus passes the registered store read and the output register.
// A stalled response holds the pending stage, and requests stall while
// both stages are occupied and the response is stalled.
// An enqueue spills (not stored) when its chosen lane is full; a dequeue
// takes normal work when the hot lane is empty or once the hot streak
// reaches the cap picked by pressure and lane fills. Store memories need
// no clearing after reset.

module hot_normal_lane_scheduler #(
   parameter int HOT_DEPTH    = hnls_pkg::HOT_DEPTH_DEF,
   parameter int NORMAL_DEPTH = hnls_pkg::NORMAL_DEPTH_DEF,
   parameter int TASK_ID_BITS = hnls_pkg::TASK_ID_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [TASK_ID_BITS-1:0]             req_task_id,
   input  logic                                req_latency_class,
   input  logic                                req_hot_requested,
   input  logic                                req_pressure,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [TASK_ID_BITS-1:0]             rsp_out_task_id,
   output logic                                rsp_out_valid,
   output logic                                rsp_from_hot,
   output logic                                rsp_placed_hot,
   output logic                                rsp_spilled,
   output logic [hnls_pkg::COUNT_BITS-1:0]     rsp_hot_count,
   output logic [hnls_pkg::COUNT_BITS-1:0]     rsp_norm_count,
   // configuration
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hnls_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [hnls_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [hnls_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import hnls_pkg::*;

   localparam int HFW = $clog2(HOT_DEPTH+1);
   localparam int NFW = $clog2(NORMAL_DEPTH+1);
   localparam int MFW = (HFW > NFW) ? HFW : NFW;
   localparam int CW  = ((MFW > CFG_BITS) ? MFW : CFG_BITS) + 1;

   cfg_type                 cfg;
   lane_cmd_type            hot_cmd;
   lane_cmd_type            norm_cmd;
   lane_stat_type           hot_stat;
   lane_stat_type           norm_stat;
   logic [HFW-1:0]          hot_fill;
   logic [NFW-1:0]          norm_fill;
   logic [TASK_ID_BITS-1:0] hot_data;
   logic [TASK_ID_BITS-1:0] norm_data;

   // Control
   logic accept;
   logic out_free;
   logic advance;

   // Policy
   logic [CW-1:0]       hot_ext;
   logic [CW-1:0]       norm_ext;
   logic                margin_ok;
   logic                contended;
   logic [CFG_BITS-1:0] cap;
   logic                place_hot;
   logic                pick_normal;
   logic                is_deq;

   // Streak and pending stage
   logic [7:0] streak_ff, streak_in;
   logic       pend_ff, pend_in;
   logic       pend_pop_ff, pend_pop_in;
   logic       pend_hot_ff, pend_hot_in;
   logic       pend_placed_ff, pend_placed_in;
   logic       pend_spill_ff, pend_spill_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [TASK_ID_BITS-1:0] rsp_id_ff;
   logic                    rsp_out_valid_ff;
   logic                    rsp_from_hot_ff;
   logic                    rsp_placed_ff;
   logic                    rsp_spill_ff;
   logic [COUNT_BITS-1:0]   rsp_hot_count_ff;
   logic [COUNT_BITS-1:0]   rsp_norm_count_ff;

   hnls_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hnls_lane #(.DEPTH(HOT_DEPTH), .DATA_BITS(TASK_ID_BITS)) u_hot_lane (
      .clock     (clock),
      .reset     (reset),
      .cmd       (hot_cmd),
      .push_data (req_task_id),
      .pop_data  (hot_data),
      .fill      (hot_fill),
      .stat      (hot_stat)
   );

   hnls_lane #(.DEPTH(NORMAL_DEPTH), .DATA_BITS(TASK_ID_BITS)) u_norm_lane (
      .clock     (clock),
      .reset     (reset),
      .cmd       (norm_cmd),
      .push_data (req_task_id),
      .pop_data  (norm_data),
      .fill      (norm_fill),
      .stat      (norm_stat)
   );

   // Handshake: pending stage drains into the output register when free
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = pend_ff && out_free;
   assign req_stall = pend_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign is_deq    = (req_kind == KIND_DEQUEUE);

   // Placement and pop policy
   assign hot_ext   = CW'(hot_fill);
   assign norm_ext  = CW'(norm_fill);
   assign margin_ok = hot_ext < (norm_ext + CW'(cfg.hot_margin));
   assign contended = norm_ext > hot_ext;

   always_comb begin
      unique case ({req_pressure, contended})
         2'b00:   cap = cfg.cap_calm;
         2'b01:   cap = cfg.cap_calm_contended;
         2'b10:   cap = cfg.cap_pressure;
         default: cap = cfg.cap_pressure_contended;
      endcase
   end

   assign place_hot   = req_latency_class || (req_hot_requested && !req_pressure && margin_ok);
   assign pick_normal = hot_stat.empty || (!norm_stat.empty && (streak_ff >= cap));

   // Lane commands
   always_comb begin
      hot_cmd  = '0;
      norm_cmd = '0;
      if (accept) begin
         if (is_deq) begin
            hot_cmd.pop  = !pick_normal;
            norm_cmd.pop = pick_normal && !norm_stat.empty;
         end else begin
            hot_cmd.push  = place_hot && !hot_stat.full;
            norm_cmd.push = !place_hot && !norm_stat.full;
         end
      end
   end

   // Streak and pending stage next state
   always_comb begin
      streak_in      = streak_ff;
      pend_in        = advance ? 1'b0 : pend_ff;
      pend_pop_in    = pend_pop_ff;
      pend_hot_in    = pend_hot_ff;
      pend_placed_in = pend_placed_ff;
      pend_spill_in  = pend_spill_ff;
      if (accept) begin
         pend_in = 1'b1;
         if (is_deq) begin
            if (pick_normal) begin
               streak_in = '0;
            end else if (streak_ff != STREAK_MAX) begin
               streak_in = streak_ff + 1'b1;
            end
            pend_pop_in    = !pick_normal || !norm_stat.empty;
            pend_hot_in    = !pick_normal;
            pend_placed_in = 1'b0;
            pend_spill_in  = 1'b0;
         end else begin
            pend_pop_in    = 1'b0;
            pend_hot_in    = 1'b0;
            pend_placed_in = place_hot;
            pend_spill_in  = place_hot ? hot_stat.full : norm_stat.full;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         streak_ff <= '0;
         pend_ff   <= 1'b0;
      end else begin
         streak_ff <= streak_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pop_ff    <= pend_pop_in;
      pend_hot_ff    <= pend_hot_in;
      pend_placed_ff <= pend_placed_in;
      pend_spill_ff  <= pend_spill_in;
   end

   // Output register; lane fills already reflect the pending item
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_id_ff         <= !pend_pop_ff ? '0 : (pend_hot_ff ? hot_data : norm_data);
         rsp_out_valid_ff  <= pend_pop_ff;
         rsp_from_hot_ff   <= pend_hot_ff;
         rsp_placed_ff     <= pend_placed_ff;
         rsp_spill_ff      <= pend_spill_ff;
         rsp_hot_count_ff  <= COUNT_BITS'(hot_fill);
         rsp_norm_count_ff <= COUNT_BITS'(norm_fill);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_task_id = rsp_id_ff;
   assign rsp_out_valid   = rsp_out_valid_ff;
   assign rsp_from_hot    = rsp_from_hot_ff;
   assign rsp_placed_hot  = rsp_placed_ff;
   assign rsp_spilled     = rsp_spill_ff;
   assign rsp_hot_count   = rsp_hot_count_ff;
   assign rsp_norm_count  = rsp_norm_count_ff;

endmodule

// File: hdl/hnls_csr.sv
// APB-style configuration register file for the lane scheduler.
// Depends on hnls_pkg for register codes, reset values and cfg_type.

module hnls_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [hnls_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [hnls_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [hnls_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready,
   output hnls_pkg::cfg_type                   cfg
);
   import hnls_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   // Write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_HOT_MARGIN:             cfg_in.hot_margin             = pwdata[CFG_BITS-1:0];
            REG_CAP_CALM:               cfg_in.cap_calm               = pwdata[CFG_BITS-1:0];
            REG_CAP_CALM_CONTENDED:     cfg_in.cap_calm_contended     = pwdata[CFG_BITS-1:0];
            REG_CAP_PRESSURE:           cfg_in.cap_pressure           = pwdata[CFG_BITS-1:0];
            REG_CAP_PRESSURE_CONTENDED: cfg_in.cap_pressure_contended = pwdata[CFG_BITS-1:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hot_margin             <= HOT_MARGIN_RST;
         cfg_ff.cap_calm               <= CAP_CALM_RST;
         cfg_ff.cap_calm_contended     <= CAP_CALM_CONTENDED_RST;
         cfg_ff.cap_pressure           <= CAP_PRESSURE_RST;
         cfg_ff.cap_pressure_contended <= CAP_PRESSURE_CONTENDED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux
   always_comb begin
      unique case (reg_idx)
         REG_HOT_MARGIN:             prdata = CSR_DATA_BITS'(cfg_ff.hot_margin);
         REG_CAP_CALM:               prdata = CSR_DATA_BITS'(cfg_ff.cap_calm);
         REG_CAP_CALM_CONTENDED:     prdata = CSR_DATA_BITS'(cfg_ff.cap_calm_contended);
         REG_CAP_PRESSURE:           prdata = CSR_DATA_BITS'(cfg_ff.cap_pressure);
         REG_CAP_PRESSURE_CONTENDED: prdata = CSR_DATA_BITS'(cfg_ff.cap_pressure_contended);
         default:                    prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/hnls_lane.sv
// One bounded task-id FIFO: synchronous store memory plus head and fill.
// Depends on hnls_pkg for lane_cmd_type and lane_stat_type.

module hnls_lane #(
   parameter int DEPTH     = hnls_pkg::HOT_DEPTH_DEF,
   parameter int DATA_BITS = hnls_pkg::TASK_ID_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  hnls_pkg::lane_cmd_type         cmd,
   input  logic [DATA_BITS-1:0]           push_data,
   output logic [DATA_BITS-1:0]           pop_data,
   output logic [$clog2(DEPTH+1)-1:0]     fill,
   output hnls_pkg::lane_stat_type        stat
);
   import hnls_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int FW = $clog2(DEPTH+1);

   logic [DATA_BITS-1:0] store [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        head_ff;
   logic [AW-1:0]        head_in;
   logic [FW-1:0]        fill_ff;
   logic [FW-1:0]        fill_in;
   logic [AW:0]          tail_sum;
   logic [AW:0]          tail_wrap;

   // Tail slot = (head + fill) mod DEPTH, sum stays below 2*DEPTH
   assign tail_sum  = {1'b0, head_ff} + (AW+1)'(fill_ff);
   assign tail_wrap = (tail_sum >= (AW+1)'(DEPTH)) ? tail_sum - (AW+1)'(DEPTH) : tail_sum;

   // Store memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         store[tail_wrap[AW-1:0]] <= push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= store[head_ff];
      end
   end

   // Pointer and occupancy
   always_comb begin
      head_in = head_ff;
      fill_in = fill_ff;
      if (cmd.pop) begin
         head_in = (head_ff == AW'(DEPTH-1)) ? '0 : head_ff + 1'b1;
         fill_in = fill_ff - 1'b1;
      end else if (cmd.push) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   assign pop_data   = rd_data_ff;
   assign fill       = fill_ff;
   assign stat.empty = (fill_ff == '0);
   assign stat.full  = (fill_ff == FW'(DEPTH));

endmodule

// File: hdl/hnls_checker.sv
// Port-level checks for the lane scheduler, bound to the top level.
// Depends on hnls_pkg and hot_normal_lane_scheduler.

module hnls_checker #(
   parameter int TASK_ID_BITS = hnls_pkg::TASK_ID_BITS_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [TASK_ID_BITS-1:0]         rsp_out_task_id,
   input logic                            rsp_out_valid,
   input logic                            rsp_from_hot,
   input logic                            rsp_placed_hot,
   input logic                            rsp_spilled,
   input logic [hnls_pkg::COUNT_BITS-1:0] rsp_hot_count,
   input logic                            pready
);
   import hnls_pkg::*;

   // Dequeue and enqueue result fields never mix
   a_kind_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_placed_hot || rsp_spilled) |-> !rsp_out_valid && !rsp_from_hot)
      else $error("enqueue result carries dequeue fields");

   // An empty or non-dequeue result shows a zero task id
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> (rsp_out_task_id == '0) && !rsp_from_hot)
      else $error("invalid pop with nonzero task id");

   // Register port is always ready
   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_task_id)
                                 && $stable(rsp_hot_count))
      else $error("stalled response changed");

endmodule

bind hot_normal_lane_scheduler hnls_checker #(.TASK_ID_BITS(TASK_ID_BITS)) u_hnls_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_out_task_id (rsp_out_task_id),
   .rsp_out_valid   (rsp_out_valid),
   .rsp_from_hot    (rsp_from_hot),
   .rsp_placed_hot  (rsp_placed_hot),
   .rsp_spilled     (rsp_spilled),
   .rsp_hot_count   (rsp_hot_count),
   .pready          (pready)
);
